@@ design/trd_pkg.sv @@
// Package with the constants, codes and result word layout of the trace page deframer.
package trd_pkg;

	localparam int PAGE_BYTES = 4096;
	localparam int FILTER_IDS = 1024;

	// Byte positions within a page and word offsets.
	localparam int POS_W  = $clog2(PAGE_BYTES + 1);
	localparam int WOFF_W = POS_W - 2;

	// Filter table index and the width used to range-check ids against it.
	localparam int IDX_W    = $clog2(FILTER_IDS);
	localparam int ID_CMP_W = 17;

	// Fixed widths of the result fields that carry byte counts.
	localparam int FIELD_W = 13;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam int SIZE_BITS = 27;
	localparam int HDR_SHORT = 12;
	localparam int HDR_LONG  = 16;

	localparam logic [1:0] COMMIT_ONE_WORD = 2'd1;

	// Event header type codes.
	localparam logic [4:0] T_DATA   = 5'd0;
	localparam logic [4:0] T_MAXLEN = 5'd28;
	localparam logic [4:0] T_PAD    = 5'd29;
	localparam logic [4:0] T_EXTEND = 5'd30;
	localparam logic [4:0] T_STAMP  = 5'd31;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_TS_HI,
		PH_COMMIT,
		PH_COMMIT_HI,
		PH_EV_HDR,
		PH_PAD_LEN,
		PH_EXT_TIME,
		PH_EXT_SIZE,
		PH_PAY_FIRST,
		PH_SKIP,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		RK_DESC = 2'd0,
		RK_FIN  = 2'd1,
		RK_ERR  = 2'd2
	} rkind_t;

	typedef enum logic [2:0] {
		ERR_COMMIT    = 3'd0,
		ERR_PAST_END  = 3'd1,
		ERR_EMPTY_PAD = 3'd2,
		ERR_EXT_SIZE  = 3'd3,
		ERR_SHORT     = 3'd4
	} err_t;

	typedef struct packed {
		rkind_t               rkind;
		logic [63:0]          ts;
		logic [15:0]          id;
		logic [FIELD_W-1:0]   off;
		logic [FIELD_W-1:0]   len;
		logic                 lost;
		logic [FIELD_W-1:0]   bytes;
		err_t                 err;
		logic                 last;
	} out_item_t;

endpackage

@@ design/trace_ring_page_deframer.sv @@
// Top level of the trace ring-buffer page deframer: header parse, event walk and result queue.
//
//  channel  | direction | handshake         | contents
//  ---------+-----------+-------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | page word or filter write (kind in s_tuser)
//  m_*      | out       | m_tvalid/m_tready | descriptor, page finished or page error
//  cfg_*    | in        | cfg_we            | commit field width in words
//
// One word is taken per cycle while s_tready is high; its results wait in the second stage
// for the synchronous read of the event enable memory, then enter the output queue and leave
// it one word per cycle while m_tready is high. After reset a clearing pass over all FILTER_IDS
// (1024) entries zeroes the enable memory; no word is taken during it, configuration writes are.
// A word yields up to two results; s_tready drops when the queue cannot hold them.
module trace_ring_page_deframer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // data_word[31:0], filter_id[41:32], filter_enable[42], zeros
	input  logic [1:0]   s_tuser,   // kind[0], first_of_page[1]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // timestamp[63:0], event_id[79:64], payload_offset[92:80],
	                                // payload_length[105:93], lost_events[106],
	                                // bytes_consumed[119:107], error_code[122:120], zeros
	output logic [1:0]   m_tuser,   // result_kind[1:0]
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata
);

	localparam int POS_W   = trd_pkg::POS_W;
	localparam int WOFF_W  = trd_pkg::WOFF_W;
	localparam int IDX_W   = trd_pkg::IDX_W;
	localparam int IDC_W   = trd_pkg::ID_CMP_W;
	localparam int FW      = trd_pkg::FIELD_W;
	localparam int FAW     = trd_pkg::FIFO_AW;
	localparam int FCW     = trd_pkg::FIFO_CW;
	localparam int CHK_W   = POS_W + 1;

	// Input decode.
	logic        s_acc, data_acc, filt_acc;
	logic [31:0] w;
	logic        first;
	logic [IDC_W-1:0] fid_ext, eid_ext;
	logic        fid_ok, eid_ok;

	// Parse state.
	trd_pkg::phase_t     phase_q, phase_n, go_phase;
	logic [WOFF_W-1:0]   woff_q, woff_n, woff_inc;
	logic [POS_W-1:0]    de_q, de_n;
	logic [63:0]         rt_q, rt_n;
	logic                lost_q, lost_n;
	logic [WOFF_W-1:0]   skip_q, skip_n, skip_cnt, skip_dec;
	logic [POS_W-1:0]    rl_q, rl_n;
	logic [1:0]          commit_words_q;

	// Decode results.
	logic                fail_v, done_req, skip_req, done_eff, page_fin, desc_cand;
	trd_pkg::err_t       fail_err;
	logic                b_valid;
	trd_pkg::rkind_t     b_kind;
	trd_pkg::err_t       b_err;
	logic [FW-1:0]       b_bytes;

	// Intermediate checks.
	logic [POS_W-1:0]    p, pos;
	logic [CHK_W-1:0]    pos_c, de_c;
	logic                rd_over;
	logic [4:0]          tl, tl_cl;
	logic [26:0]         delta;
	logic [27:0]         commit_end;
	logic [POS_W-1:0]    rem, target;
	logic [CHK_W-1:0]    target_up, pay_up;
	logic [31:0]         pl;
	logic [32:0]         pl_end;

	// Enable memory and clearing pass.
	logic                en_mem [trd_pkg::FILTER_IDS];
	logic                en_rd_q;
	logic                clearing_q;
	logic [IDX_W-1:0]    clr_idx_q;
	logic                mem_we, mem_wd;
	logic [IDX_W-1:0]    mem_wa, rd_idx;

	// Second stage.
	logic                valid_s2, desc_cand_s2, b_valid_s2, lost_s2;
	logic [63:0]         ts_s2;
	logic [15:0]         id_s2;
	logic [FW-1:0]       off_s2, len_s2, bytes_s2;
	trd_pkg::rkind_t     b_kind_s2;
	trd_pkg::err_t       b_err_s2;

	// Result queue.
	trd_pkg::out_item_t  fifo_q [trd_pkg::FIFO_DEPTH];
	logic [FAW-1:0]      head_q, tail_q;
	logic [FCW-1:0]      cnt_q;
	logic                desc_ok, b_ok, pop;
	logic [1:0]          push_n, s2_n;
	trd_pkg::out_item_t  item_a, item_b, head_item;

	assign s_acc    = s_tvalid && s_tready;
	assign data_acc = s_acc && !s_tuser[0];
	assign filt_acc = s_acc && s_tuser[0];
	assign w        = s_tdata[31:0];
	assign first    = s_tuser[1];

	assign fid_ext = IDC_W'(s_tdata[41:32]);
	assign eid_ext = IDC_W'(w[15:0]);
	assign fid_ok  = fid_ext < IDC_W'(trd_pkg::FILTER_IDS);
	assign eid_ok  = eid_ext < IDC_W'(trd_pkg::FILTER_IDS);

	// Shared position arithmetic.
	assign p        = {woff_q, 2'b00};
	assign pos      = p + POS_W'(4);
	assign pos_c    = CHK_W'(pos);
	assign de_c     = CHK_W'(de_q);
	assign rd_over  = (CHK_W'(p) + CHK_W'(4)) > de_c;
	assign woff_inc = woff_q + WOFF_W'(1);
	assign tl       = w[4:0];
	assign delta    = w[31:5];
	assign tl_cl    = (tl <= trd_pkg::T_MAXLEN) ? tl : trd_pkg::T_MAXLEN;
	assign commit_end = ((commit_words_q == trd_pkg::COMMIT_ONE_WORD) ?
		28'(trd_pkg::HDR_SHORT) : 28'(trd_pkg::HDR_LONG)) + 28'(w[trd_pkg::SIZE_BITS-1:0]);
	assign rem       = de_q - pos;
	assign target    = (w < 32'(rem)) ? w[POS_W-1:0] : rem;
	assign target_up = CHK_W'(target) + CHK_W'(3);
	assign pay_up    = CHK_W'(rl_q) + CHK_W'(3);
	assign pl        = w - 32'd4;
	assign pl_end    = {1'b0, pl} + 33'(pos);
	assign skip_dec  = (skip_q == '0) ? '0 : skip_q - WOFF_W'(1);

	// Word decode: datapath next values and what the word asks of the phase logic.
	always_comb begin
		woff_n    = woff_q;
		de_n      = de_q;
		rt_n      = rt_q;
		lost_n    = lost_q;
		rl_n      = rl_q;
		fail_v    = 1'b0;
		fail_err  = trd_pkg::ERR_COMMIT;
		done_req  = 1'b0;
		skip_req  = 1'b0;
		skip_cnt  = '0;
		go_phase  = phase_q;
		desc_cand = 1'b0;
		if (data_acc) begin
			if (first) begin
				rt_n     = {32'd0, w};
				lost_n   = 1'b0;
				woff_n   = WOFF_W'(1);
				go_phase = trd_pkg::PH_TS_HI;
			end else begin
				case (phase_q)
					trd_pkg::PH_TS_HI: begin
						rt_n[63:32] = w;
						woff_n      = woff_inc;
						go_phase    = trd_pkg::PH_COMMIT;
					end
					trd_pkg::PH_COMMIT: begin
						lost_n = w[31];
						woff_n = woff_inc;
						if (commit_end > 28'(trd_pkg::PAGE_BYTES)) begin
							fail_v   = 1'b1;
							fail_err = trd_pkg::ERR_COMMIT;
						end else begin
							de_n = commit_end[POS_W-1:0];
							if (commit_words_q == trd_pkg::COMMIT_ONE_WORD) begin
								done_req = 1'b1;
							end else begin
								go_phase = trd_pkg::PH_COMMIT_HI;
							end
						end
					end
					trd_pkg::PH_COMMIT_HI: begin
						woff_n   = woff_inc;
						done_req = 1'b1;
					end
					trd_pkg::PH_EV_HDR, trd_pkg::PH_PAD_LEN,
					trd_pkg::PH_EXT_TIME, trd_pkg::PH_EXT_SIZE: begin
						if (rd_over) begin
							fail_v   = 1'b1;
							fail_err = trd_pkg::ERR_PAST_END;
						end else begin
							woff_n = woff_inc;
							case (phase_q)
								trd_pkg::PH_EV_HDR: begin
									rt_n = rt_q + 64'(delta);
									if (tl == trd_pkg::T_PAD) begin
										if (delta == '0) begin
											fail_v   = 1'b1;
											fail_err = trd_pkg::ERR_EMPTY_PAD;
										end else begin
											go_phase = trd_pkg::PH_PAD_LEN;
										end
									end else if (tl == trd_pkg::T_EXTEND) begin
										go_phase = trd_pkg::PH_EXT_TIME;
									end else if (tl == trd_pkg::T_STAMP) begin
										if (pos_c + CHK_W'(16) > de_c) begin
											fail_v   = 1'b1;
											fail_err = trd_pkg::ERR_PAST_END;
										end else begin
											skip_req = 1'b1;
											skip_cnt = WOFF_W'(4);
										end
									end else if (tl == trd_pkg::T_DATA) begin
										go_phase = trd_pkg::PH_EXT_SIZE;
									end else begin
										if (pos_c + CHK_W'({tl_cl, 2'b00}) > de_c) begin
											fail_v   = 1'b1;
											fail_err = trd_pkg::ERR_PAST_END;
										end else begin
											rl_n     = POS_W'({tl_cl, 2'b00});
											go_phase = trd_pkg::PH_PAY_FIRST;
										end
									end
								end
								trd_pkg::PH_PAD_LEN: begin
									skip_req = 1'b1;
									skip_cnt = WOFF_W'(target_up[CHK_W-1:2]);
								end
								trd_pkg::PH_EXT_TIME: begin
									rt_n     = rt_q + {5'd0, w, 27'd0};
									done_req = 1'b1;
								end
								default: begin
									// Extended record size word.
									if (w < 32'd4) begin
										fail_v   = 1'b1;
										fail_err = trd_pkg::ERR_EXT_SIZE;
									end else if (pl_end > 33'(de_q)) begin
										fail_v   = 1'b1;
										fail_err = trd_pkg::ERR_PAST_END;
									end else if (pl < 32'd4) begin
										fail_v   = 1'b1;
										fail_err = trd_pkg::ERR_SHORT;
									end else begin
										rl_n     = pl[POS_W-1:0];
										go_phase = trd_pkg::PH_PAY_FIRST;
									end
								end
							endcase
						end
					end
					trd_pkg::PH_PAY_FIRST: begin
						desc_cand = eid_ok;
						woff_n    = woff_inc;
						skip_req  = 1'b1;
						skip_cnt  = WOFF_W'(pay_up[CHK_W-1:2]) - WOFF_W'(1);
					end
					trd_pkg::PH_SKIP: begin
						woff_n   = woff_inc;
						skip_req = 1'b1;
						skip_cnt = skip_dec;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// A finished item with the next position at or past the data end closes the page.
	assign done_eff = done_req || (skip_req && (skip_cnt == '0));
	assign page_fin = done_eff && ({woff_n, 2'b00} >= de_n);

	// Next phase.
	always_comb begin
		phase_n = go_phase;
		skip_n  = skip_q;
		if (fail_v) begin
			phase_n = trd_pkg::PH_DONE;
		end else if (done_eff) begin
			phase_n = page_fin ? trd_pkg::PH_DONE : trd_pkg::PH_EV_HDR;
		end else if (skip_req) begin
			phase_n = trd_pkg::PH_SKIP;
			skip_n  = skip_cnt;
		end
	end

	// Page-level result of the word.
	always_comb begin
		b_valid = fail_v || page_fin;
		b_kind  = fail_v ? trd_pkg::RK_ERR : trd_pkg::RK_FIN;
		b_err   = fail_v ? fail_err : trd_pkg::ERR_COMMIT;
		b_bytes = fail_v ? '0 : FW'(de_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= trd_pkg::PH_WAIT;
			woff_q         <= '0;
			de_q           <= '0;
			rt_q           <= '0;
			lost_q         <= 1'b0;
			skip_q         <= '0;
			rl_q           <= '0;
			commit_words_q <= 2'd2;
		end else begin
			phase_q <= phase_n;
			woff_q  <= woff_n;
			de_q    <= de_n;
			rt_q    <= rt_n;
			lost_q  <= lost_n;
			skip_q  <= skip_n;
			rl_q    <= rl_n;
			if (cfg_we) begin
				commit_words_q <= cfg_wdata;
			end
		end
	end

	// Enable memory: one write port shared by the clearing pass and filter writes.
	assign mem_we = clearing_q || (filt_acc && fid_ok);
	assign mem_wa = clearing_q ? clr_idx_q : fid_ext[IDX_W-1:0];
	assign mem_wd = clearing_q ? 1'b0 : s_tdata[42];
	assign rd_idx = eid_ext[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			en_mem[mem_wa] <= mem_wd;
		end
		en_rd_q <= en_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDX_W'(trd_pkg::FILTER_IDS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
		end
	end

	// Second stage waits for the enable bit of a record's id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= desc_cand || b_valid;
		end
	end

	always_ff @(posedge clk) begin
		desc_cand_s2 <= desc_cand;
		b_valid_s2   <= b_valid;
		lost_s2      <= lost_n;
		ts_s2        <= rt_q;
		id_s2        <= w[15:0];
		off_s2       <= FW'(p);
		len_s2       <= FW'(rl_q);
		bytes_s2     <= b_bytes;
		b_kind_s2    <= b_kind;
		b_err_s2     <= b_err;
	end

	assign desc_ok = valid_s2 && desc_cand_s2 && en_rd_q;
	assign b_ok    = valid_s2 && b_valid_s2;
	assign push_n  = 2'(desc_ok) + 2'(b_ok);
	assign s2_n    = valid_s2 ? (2'(desc_cand_s2) + 2'(b_valid_s2)) : 2'd0;
	assign pop     = m_tvalid && m_tready;

	always_comb begin
		item_a.rkind = trd_pkg::RK_DESC;
		item_a.ts    = ts_s2;
		item_a.id    = id_s2;
		item_a.off   = off_s2;
		item_a.len   = len_s2;
		item_a.lost  = lost_s2;
		item_a.bytes = '0;
		item_a.err   = trd_pkg::ERR_COMMIT;
		item_a.last  = !b_valid_s2;

		item_b.rkind = b_kind_s2;
		item_b.ts    = '0;
		item_b.id    = '0;
		item_b.off   = '0;
		item_b.len   = '0;
		item_b.lost  = lost_s2;
		item_b.bytes = bytes_s2;
		item_b.err   = b_err_s2;
		item_b.last  = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (desc_ok) begin
			fifo_q[tail_q] <= item_a;
		end
		if (b_ok) begin
			fifo_q[desc_ok ? tail_q + FAW'(1) : tail_q] <= item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + FAW'(push_n);
			head_q <= head_q + FAW'(pop);
			cnt_q  <= cnt_q + FCW'(push_n) - FCW'(pop);
		end
	end

	// Room for what the second stage holds plus two results of a new word.
	assign s_tready = !clearing_q &&
		((FCW + 1)'(cnt_q) + (FCW + 1)'(s2_n) + (FCW + 1)'(2) <=
		 (FCW + 1)'(trd_pkg::FIFO_DEPTH));

	assign head_item = fifo_q[head_q];
	assign m_tvalid  = cnt_q != '0;
	assign m_tuser   = head_item.rkind;
	assign m_tlast   = head_item.last;
	assign m_tdata   = {5'd0, head_item.err, head_item.bytes, head_item.lost, head_item.len,
		head_item.off, head_item.id, head_item.ts};

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FCW'(trd_pkg::FIFO_DEPTH))
		else $error("result queue holds more words than its depth");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == trd_pkg::PH_SKIP |-> skip_q != '0)
		else $error("skip phase with no words left to skip");

	a_data_end: assert property (@(posedge clk) disable iff (!arst_n)
		de_q <= POS_W'(trd_pkg::PAGE_BYTES))
		else $error("data end beyond the page");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("enable memory clearing restarted");

endmodule

@@ sim/tb_trace_ring_page_deframer.sv @@
// Self-checking testbench for the trace ring-buffer page deframer.
`timescale 1ns / 100ps

module tb_trace_ring_page_deframer;

	import trd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 12;

	// The error field reads zero outside page errors.
	localparam err_t NO_ERR = ERR_COMMIT;

	typedef struct packed {
		logic        kind;
		logic [31:0] word;
		logic        first;
		logic [9:0]  fid;
		logic        fen;
	} page_in_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [47:0]  s_tdata = '0;   // data_word[31:0], filter_id[41:32], filter_enable[42], zeros
	logic [1:0]   s_tuser = '0;   // kind[0], first_of_page[1]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // timestamp[63:0], event_id[79:64], payload_offset[92:80],
	                              // payload_length[105:93], lost_events[106],
	                              // bytes_consumed[119:107], error_code[122:120], zeros
	logic [1:0]   m_tuser;        // result_kind[1:0]
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_wdata = '0;

	trace_ring_page_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	page_in_t    word_q [$];
	out_item_t   exp_q [$];
	logic [31:0] body [$];
	page_in_t    bus_item;
	logic        steady = 1'b0;
	int          queued_words = 0;
	int          words_in = 0;
	int          results_out = 0;
	int          n_desc = 0;
	int          n_fin = 0;
	int          n_err = 0;
	int          mismatches = 0;
	int          cycles = 0;

	// Page walker state, mirrored from the block.
	phase_t      pg_phase;
	int          pg_woff;
	int          pg_end;
	int          pg_skip;
	int          pg_len;
	logic [63:0] pg_time;
	logic        pg_lost;
	logic        enable_map [FILTER_IDS];
	logic [1:0]  commit_cfg = 2'd2;
	out_item_t   step_res [2];
	int          step_n;

	task automatic emit_result(input rkind_t rk, input logic [63:0] ts, input logic [15:0] id,
			input int off, input int len, input int bytes, input err_t err);
		out_item_t r;
		r.rkind = rk;
		r.ts    = ts;
		r.id    = id;
		r.off   = FIELD_W'(off);
		r.len   = FIELD_W'(len);
		r.lost  = pg_lost;
		r.bytes = FIELD_W'(bytes);
		r.err   = err;
		r.last  = 1'b0;
		step_res[step_n] = r;
		step_n++;
	endtask

	task automatic page_fail(input err_t err);
		pg_phase = PH_DONE;
		emit_result(RK_ERR, 64'd0, 16'd0, 0, 0, 0, err);
	endtask

	// An item ended on a word boundary: either the page is finished or a header follows.
	task automatic item_end();
		if (pg_woff * 4 >= pg_end) begin
			pg_phase = PH_DONE;
			emit_result(RK_FIN, 64'd0, 16'd0, 0, 0, pg_end, NO_ERR);
		end else begin
			pg_phase = PH_EV_HDR;
		end
	endtask

	task automatic skip_or_end(input int words);
		if (words == 0) begin
			item_end();
		end else begin
			pg_skip = words;
			pg_phase = PH_SKIP;
		end
	endtask

	task automatic predict_word(input page_in_t it);
		int          p;
		int          pos;
		int          hdr;
		int          len;
		int          rem;
		int          i;
		longint      endv;
		longint      wl;
		longint      pl;
		longint      target;
		logic [4:0]  tl;
		logic [26:0] delta;
		logic [15:0] eid;
		logic [31:0] w;
		out_item_t   r;
		step_n = 0;
		w = it.word;
		wl = w;
		if (it.kind) begin
			enable_map[it.fid] = it.fen;
		end else if (it.first) begin
			pg_time = {32'd0, w};
			pg_lost = 1'b0;
			pg_woff = 1;
			pg_phase = PH_TS_HI;
		end else begin
			p = pg_woff * 4;
			case (pg_phase)
				PH_TS_HI: begin
					pg_time[63:32] = pg_time[63:32] | w;
					pg_woff++;
					pg_phase = PH_COMMIT;
				end
				PH_COMMIT: begin
					hdr = (commit_cfg == COMMIT_ONE_WORD) ? HDR_SHORT : HDR_LONG;
					endv = w[SIZE_BITS-1:0];
					endv = endv + hdr;
					pg_lost = w[31];
					pg_woff++;
					if (endv > PAGE_BYTES) begin
						page_fail(ERR_COMMIT);
					end else begin
						pg_end = int'(endv);
						if (hdr == HDR_LONG)
							pg_phase = PH_COMMIT_HI;
						else
							item_end();
					end
				end
				PH_COMMIT_HI: begin
					pg_woff++;
					item_end();
				end
				PH_EV_HDR, PH_PAD_LEN, PH_EXT_TIME, PH_EXT_SIZE: begin
					if (p + 4 > pg_end) begin
						page_fail(ERR_PAST_END);
					end else begin
						pg_woff++;
						pos = p + 4;
						case (pg_phase)
							PH_EV_HDR: begin
								tl = w[4:0];
								delta = w[31:5];
								pg_time = pg_time + 64'(delta);
								if (tl == T_PAD) begin
									if (delta == 0)
										page_fail(ERR_EMPTY_PAD);
									else
										pg_phase = PH_PAD_LEN;
								end else if (tl == T_EXTEND) begin
									pg_phase = PH_EXT_TIME;
								end else if (tl == T_STAMP) begin
									if (pos + 16 > pg_end)
										page_fail(ERR_PAST_END);
									else
										skip_or_end(4);
								end else if (tl == T_DATA) begin
									pg_phase = PH_EXT_SIZE;
								end else begin
									len = 4 * int'(tl);
									if (pos + len > pg_end) begin
										page_fail(ERR_PAST_END);
									end else begin
										pg_len = len;
										pg_phase = PH_PAY_FIRST;
									end
								end
							end
							PH_PAD_LEN: begin
								// Padding that runs past the data end is cut at the end.
								rem = pg_end - pos;
								target = (wl < rem) ? wl : rem;
								skip_or_end(int'((target + 3) >> 2));
							end
							PH_EXT_TIME: begin
								pg_time = pg_time + (64'(w) << SIZE_BITS);
								item_end();
							end
							default: begin
								if (wl < 4) begin
									page_fail(ERR_EXT_SIZE);
								end else begin
									pl = wl - 4;
									if (pos + pl > pg_end) begin
										page_fail(ERR_PAST_END);
									end else if (pl < 4) begin
										page_fail(ERR_SHORT);
									end else begin
										pg_len = int'(pl);
										pg_phase = PH_PAY_FIRST;
									end
								end
							end
						endcase
					end
				end
				PH_PAY_FIRST: begin
					eid = w[15:0];
					if (eid < FILTER_IDS && enable_map[eid[IDX_W-1:0]])
						emit_result(RK_DESC, pg_time, eid, p, pg_len, 0, NO_ERR);
					pg_woff++;
					skip_or_end(((pg_len + 3) >> 2) - 1);
				end
				PH_SKIP: begin
					pg_woff++;
					if (pg_skip > 0)
						pg_skip--;
					if (pg_skip == 0)
						item_end();
				end
				default: ;
			endcase
		end
		for (i = 0; i < step_n; i++) begin
			r = step_res[i];
			r.last = (i == step_n - 1);
			exp_q.push_back(r);
		end
	endtask

	function automatic string show(input out_item_t r);
		return $sformatf("kind %0d ts %h id %h off %0d len %0d lost %b bytes %0d err %0d last %b",
			r.rkind, r.ts, r.id, r.off, r.len, r.lost, r.bytes, r.err, r.last);
	endfunction

	// Stimulus building.

	task automatic queue_data(input logic [31:0] w, input logic first);
		page_in_t it;
		it.kind  = 1'b0;
		it.word  = w;
		it.first = first;
		it.fid   = 10'($urandom());
		it.fen   = 1'($urandom());
		word_q.push_back(it);
		queued_words++;
	endtask

	task automatic queue_filter(input logic [9:0] id, input logic en);
		page_in_t it;
		it.kind  = 1'b1;
		it.word  = $urandom();
		it.first = 1'($urandom());
		it.fid   = id;
		it.fen   = en;
		word_q.push_back(it);
	endtask

	task automatic random_filter();
		logic [9:0] id;
		id = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 15));
		queue_filter(id, $urandom_range(0, 2) != 0);
	endtask

	function automatic logic [26:0] rand_delta();
		return ($urandom_range(0, 7) == 0) ? 27'($urandom()) : 27'($urandom_range(0, 1000));
	endfunction

	function automatic logic [26:0] pad_delta();
		logic [26:0] d;
		d = rand_delta();
		return (d == 0) ? 27'd1 : d;
	endfunction

	function automatic logic [15:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 16'($urandom_range(0, 15));
		else if (r == 7)
			return 16'(FILTER_IDS - 1);
		else if (r == 8)
			return 16'($urandom_range(FILTER_IDS, 65535));
		else
			return 16'($urandom_range(0, FILTER_IDS - 1));
	endfunction

	task automatic add_payload(input int bytes);
		logic [31:0] w;
		w = $urandom();
		w[15:0] = pick_id();
		body.push_back(w);
		repeat (((bytes + 3) >> 2) - 1) body.push_back($urandom());
	endtask

	task automatic add_record();
		int r;
		int tl;
		int pl;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			tl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, T_MAXLEN) : $urandom_range(1, 4);
			body.push_back({rand_delta(), 5'(tl)});
			add_payload(4 * tl);
		end else if (r < 62) begin
			body.push_back({rand_delta(), T_DATA});
			if ($urandom_range(0, 15) == 0) begin
				// Size word too small for a valid record.
				body.push_back($urandom_range(0, 7));
			end else begin
				pl = $urandom_range(4, 24);
				body.push_back(pl + 4);
				add_payload(pl);
			end
		end else if (r < 74) begin
			pl = $urandom_range(1, 16);
			body.push_back({pad_delta(), T_PAD});
			body.push_back(pl);
			repeat ((pl + 3) >> 2) body.push_back($urandom());
		end else if (r < 87) begin
			body.push_back({rand_delta(), T_EXTEND});
			body.push_back($urandom());
		end else begin
			body.push_back({rand_delta(), T_STAMP});
			repeat (4) body.push_back($urandom());
		end
	endtask

	// Broken pages are cut short, carry a wrong size, a corrupted word or trailing strays.
	task automatic gen_page(input bit broken);
		int          nrec;
		int          mode;
		int          cut;
		int          nbytes;
		int          k;
		logic [31:0] commit;
		logic [31:0] ts_lo;
		logic [31:0] ts_hi;
		body.delete();
		nrec = $urandom_range(0, 6);
		for (k = 0; k < nrec; k++)
			add_record();
		if ($urandom_range(0, 6) == 0) begin
			body.push_back({pad_delta(), T_PAD});
			body.push_back($urandom() | 32'h100);
			repeat ($urandom_range(0, 3)) body.push_back($urandom());
		end
		nbytes = 4 * body.size();
		mode = broken ? $urandom_range(0, 4) : 5;
		if (mode == 0 && body.size() > 0)
			nbytes = nbytes - 4 * $urandom_range(1, body.size());
		if (mode == 1 && body.size() > 0)
			body[$urandom_range(0, body.size() - 1)] = $urandom();
		commit = $urandom();
		commit[SIZE_BITS-1:0] = 27'(nbytes);
		if (mode == 3)
			commit[SIZE_BITS-1:0] = ($urandom_range(0, 1) == 1) ? 27'($urandom())
			                                                   : 27'($urandom_range(0, 4200));
		ts_lo = $urandom();
		ts_hi = $urandom();
		if ($urandom_range(0, 9) == 0) begin
			ts_lo = 32'hFFFF_FFFF;
			ts_hi = 32'hFFFF_FFFF;
		end
		queue_data(ts_lo, 1'b1);
		queue_data(ts_hi, 1'b0);
		queue_data(commit, 1'b0);
		if (commit_cfg != COMMIT_ONE_WORD)
			queue_data($urandom(), 1'b0);
		cut = (mode == 2) ? $urandom_range(0, body.size()) : body.size();
		for (k = 0; k < cut; k++) begin
			if ($urandom_range(0, 19) == 0)
				random_filter();
			queue_data(body[k], 1'b0);
		end
		if (mode == 4)
			repeat ($urandom_range(1, 3)) queue_data($urandom(), 1'b0);
	endtask

	task automatic random_phase(input int n_words);
		int target;
		int r;
		target = queued_words + n_words;
		while (queued_words < target) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				queue_data($urandom(), 1'b0);
			else if (r < 14)
				random_filter();
			else
				gen_page(r >= 85);
		end
	endtask

	task automatic wait_idle();
		while (word_q.size() != 0 || s_tvalid || exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_commit_width(input logic [1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		commit_cfg = v;
	endtask

	// Driver: a word stays on the bus until taken; prediction runs on each accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			pg_phase = PH_WAIT;
			pg_woff = 0;
			pg_end = 0;
			pg_time = '0;
			pg_lost = 1'b0;
			pg_skip = 0;
			pg_len = 0;
			for (int i = 0; i < FILTER_IDS; i++)
				enable_map[i] = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_word(bus_item);
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					bus_item = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'd0, bus_item.fen, bus_item.fid, bus_item.word};
					s_tuser <= {bus_item.first, bus_item.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result word with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		out_item_t seen;
		out_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.rkind = rkind_t'(m_tuser);
				seen.ts    = m_tdata[63:0];
				seen.id    = m_tdata[79:64];
				seen.off   = m_tdata[92:80];
				seen.len   = m_tdata[105:93];
				seen.lost  = m_tdata[106];
				seen.bytes = m_tdata[119:107];
				seen.err   = err_t'(m_tdata[122:120]);
				seen.last  = m_tlast;
				results_out++;
				case (seen.rkind)
					RK_DESC: n_desc++;
					RK_FIN:  n_fin++;
					default: n_err++;
				endcase
				if (exp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d: %s", results_out, show(seen));
				end else begin
					want = exp_q.pop_front();
					if (seen !== want || m_tdata[127:123] !== '0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d mismatch (pad bits %b)", results_out,
								m_tdata[127:123]);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(seen));
						end
					end
				end
			end
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, exp_q.size());
			$display("trace_ring_page_deframer regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pages with the reset width of two commit words.
		queue_filter(10'd5, 1'b1);
		queue_filter(10'(FILTER_IDS - 1), 1'b1);
		queue_data(32'h1234_5678, 1'b0);
		// Timestamp at its maximum wraps on the first delta; lost flag set.
		queue_data(32'hFFFF_FFFF, 1'b1);
		queue_data(32'hFFFF_FFFF, 1'b0);
		queue_data(32'h8000_0018, 1'b0);
		queue_data(32'hFFFF_FFFF, 1'b0);
		queue_data({27'h7FF_FFFF, 5'd1}, 1'b0);
		queue_data(32'hABCD_0005, 1'b0);
		queue_data({27'd0, T_DATA}, 1'b0);
		queue_data(32'd9, 1'b0);
		queue_data(32'h0000_03FF, 1'b0);
		queue_data(32'h5555_AAAA, 1'b0);
		// Empty page finishes on its last header word.
		queue_data(32'd1, 1'b1);
		queue_data(32'd0, 1'b0);
		queue_data(32'd0, 1'b0);
		queue_data(32'd0, 1'b0);
		// Size field far beyond the page.
		queue_data(32'd2, 1'b1);
		queue_data(32'd0, 1'b0);
		queue_data(32'h7FFF_FFFF, 1'b0);
		// Padding with a zero delta.
		queue_data(32'd3, 1'b1);
		queue_data(32'd0, 1'b0);
		queue_data(32'd8, 1'b0);
		queue_data(32'd0, 1'b0);
		queue_data({27'd0, T_PAD}, 1'b0);
		wait_idle();

		set_commit_width(COMMIT_ONE_WORD);
		repeat (12) random_filter();
		random_phase(150);
		wait_idle();

		set_commit_width(2'd2);
		steady <= 1'b1;
		random_phase(150);
		wait_idle();

		steady <= 1'b0;
		set_commit_width(COMMIT_ONE_WORD);
		random_phase(150);
		wait_idle();

		$display("covered %0d input words and %0d results: %0d records, %0d finished pages, %0d page errors",
			words_in, results_out, n_desc, n_fin, n_err);
		$display("commit field widths of two, one, two and one words; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("trace_ring_page_deframer regression: pass");
		else
			$display("trace_ring_page_deframer regression: fail");
		$finish;
	end

endmodule
